/* hw/rtl/pnl_pkg.sv */
package pnl_pkg;

  localparam int unsigned IdxW      = 10;
  localparam int unsigned FieldPosW = 24;
  localparam int unsigned BoxW      = 24;
  localparam int unsigned CutW      = 50;
  localparam int unsigned AtomCntW  = 11;
  localparam int unsigned NeighMaxW = 7;
  localparam int unsigned SlotW     = 17;
  localparam int unsigned CountW    = 7;
  localparam int unsigned ShiftW    = 2;

  localparam int unsigned ApbAddrW  = 6;
  localparam int unsigned ApbDataW  = 64;
  localparam int unsigned RegSelW   = 3;

  localparam int unsigned InTdataW  = 88;
  localparam int unsigned OutTdataW = 56;

  localparam logic [SlotW-1:0] SlotMax = '1;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic [RegSelW-1:0] RegBoxX     = 3'd0;
  localparam logic [RegSelW-1:0] RegBoxY     = 3'd1;
  localparam logic [RegSelW-1:0] RegBoxZ     = 3'd2;
  localparam logic [RegSelW-1:0] RegCutoffSq = 3'd3;
  localparam logic [RegSelW-1:0] RegAtomCnt  = 3'd4;
  localparam logic [RegSelW-1:0] RegNeighMax = 3'd5;

  localparam logic [ShiftW-1:0] ShiftNone = 2'b00;
  localparam logic [ShiftW-1:0] ShiftPos  = 2'b01;
  localparam logic [ShiftW-1:0] ShiftNeg  = 2'b11;

  typedef struct packed {
    logic [BoxW-1:0]      box_x;
    logic [BoxW-1:0]      box_y;
    logic [BoxW-1:0]      box_z;
    logic [CutW-1:0]      cutoff_sq;
    logic [AtomCntW-1:0]  atom_count;
    logic [NeighMaxW-1:0] neigh_max;
  } cfg_t;

  typedef struct packed {
    logic [IdxW-1:0]   center_index;
    logic [IdxW-1:0]   neighbor_index;
    logic [SlotW-1:0]  slot_index;
    logic [ShiftW-1:0] shift_x;
    logic [ShiftW-1:0] shift_y;
    logic [ShiftW-1:0] shift_z;
    logic              neighbor_valid;
    logic [CountW-1:0] neighbor_count;
    logic              overflow;
  } res_t;

endpackage

/* hw/rtl/pnl_ram.sv */
module pnl_ram #(
  parameter int unsigned Width = 72,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/pnl_cfg.sv */
module pnl_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pnl_pkg::ApbAddrW-1:0]   paddr,
  input  logic [pnl_pkg::ApbDataW-1:0]   pwdata,
  output logic [pnl_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready,
  output pnl_pkg::cfg_t                  cfg_o
);
  import pnl_pkg::*;

  logic [BoxW-1:0]      box_x_q, box_y_q, box_z_q;
  logic [CutW-1:0]      cutoff_q;
  logic [AtomCntW-1:0]  atom_cnt_q;
  logic [NeighMaxW-1:0] neigh_max_q;
  logic                 wr_en;
  logic [RegSelW-1:0]   reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[ApbAddrW-1:ApbAddrW-RegSelW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_x_q     <= '1;
      box_y_q     <= '1;
      box_z_q     <= '1;
      cutoff_q    <= '0;
      atom_cnt_q  <= '0;
      neigh_max_q <= NeighMaxW'(64);
    end else if (wr_en) begin
      unique case (reg_sel)
        RegBoxX:     box_x_q     <= pwdata[BoxW-1:0];
        RegBoxY:     box_y_q     <= pwdata[BoxW-1:0];
        RegBoxZ:     box_z_q     <= pwdata[BoxW-1:0];
        RegCutoffSq: cutoff_q    <= pwdata[CutW-1:0];
        RegAtomCnt:  atom_cnt_q  <= pwdata[AtomCntW-1:0];
        RegNeighMax: neigh_max_q <= pwdata[NeighMaxW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegBoxX:     prdata = ApbDataW'(box_x_q);
      RegBoxY:     prdata = ApbDataW'(box_y_q);
      RegBoxZ:     prdata = ApbDataW'(box_z_q);
      RegCutoffSq: prdata = ApbDataW'(cutoff_q);
      RegAtomCnt:  prdata = ApbDataW'(atom_cnt_q);
      RegNeighMax: prdata = ApbDataW'(neigh_max_q);
      default:     prdata = '0;
    endcase
  end

  assign cfg_o.box_x      = box_x_q;
  assign cfg_o.box_y      = box_y_q;
  assign cfg_o.box_z      = box_z_q;
  assign cfg_o.cutoff_sq  = cutoff_q;
  assign cfg_o.atom_count = atom_cnt_q;
  assign cfg_o.neigh_max  = neigh_max_q;

endmodule

/* hw/rtl/pnl_axis_unit.sv */
module pnl_axis_unit #(
  parameter int unsigned PosW = 24
) (
  input  logic                clk_i,
  input  logic [PosW-1:0]     a_i,
  input  logic [PosW-1:0]     b_i,
  input  logic [PosW-1:0]     len_i,
  output logic [1:0]          shift_o,
  output logic [2*PosW-1:0]   sq_o
);
  import pnl_pkg::*;

  localparam int unsigned EW = PosW + 3;

  logic signed [EW-1:0] diff, len_s, twice, adj, mag_w;
  logic                 pos_c, neg_c;
  logic [ShiftW-1:0]    shift_d, shift_q;
  logic [PosW-1:0]      mag_d, mag_q;
  logic [2*PosW-1:0]    sq_q;

  always_comb begin
    diff  = $signed(EW'(a_i)) - $signed(EW'(b_i));
    len_s = $signed(EW'(len_i));
    twice = diff <<< 1;
    pos_c = (diff > 0) && (twice >= len_s);
    neg_c = (diff < 0) && ((twice + len_s) <= 0);
    priority if (pos_c) begin
      adj     = diff - len_s;
      shift_d = ShiftPos;
    end else if (neg_c) begin
      adj     = diff + len_s;
      shift_d = ShiftNeg;
    end else begin
      adj     = diff;
      shift_d = ShiftNone;
    end
    mag_w = adj[EW-1] ? -adj : adj;
    mag_d = mag_w[PosW-1:0];
  end

  // stage 1 shift and magnitude, stage 2 square
  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    mag_q   <= mag_d;
    sq_q    <= mag_q * mag_q;
  end

  assign shift_o = shift_q;
  assign sq_o    = sq_q;

endmodule

/* hw/rtl/pnl_seq.sv */
module pnl_seq #(
  parameter int unsigned MAX_ATOMS   = 1024,
  parameter int unsigned NEIGH_LIMIT = 64,
  parameter int unsigned POS_BITS    = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pnl_pkg::cfg_t                     cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              in_opcode_i,
  input  logic [pnl_pkg::IdxW-1:0]          in_index_i,
  input  logic [pnl_pkg::FieldPosW-1:0]     in_pos_x_i,
  input  logic [pnl_pkg::FieldPosW-1:0]     in_pos_y_i,
  input  logic [pnl_pkg::FieldPosW-1:0]     in_pos_z_i,
  output logic                              ram_en_o,
  output logic                              ram_we_o,
  output logic [$clog2(MAX_ATOMS)-1:0]      ram_addr_o,
  output logic [3*POS_BITS-1:0]             ram_wdata_o,
  input  logic [3*POS_BITS-1:0]             ram_rdata_i,
  output logic [POS_BITS-1:0]               ax_a_o,
  output logic [POS_BITS-1:0]               ax_b_o,
  output logic [POS_BITS-1:0]               ax_len_o,
  input  logic [1:0]                        ax_shift_i,
  input  logic [2*POS_BITS-1:0]             ax_sq_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output pnl_pkg::res_t                     out_res_o,
  output logic                              out_last_o
);
  import pnl_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_ATOMS);
  localparam int unsigned CW    = $clog2(MAX_ATOMS + 1);
  localparam int unsigned PW    = POS_BITS;
  localparam int unsigned ACCW  = 2 * POS_BITS + 2;
  localparam int unsigned CMPW  = (ACCW > CutW) ? ACCW : CutW;
  localparam logic [SlotW-1:0]  MaxAtomsW  = SlotW'(MAX_ATOMS);
  localparam logic [CountW-1:0] NeighLimW  = CountW'(NEIGH_LIMIT);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StCen  = 4'd1;
  localparam logic [3:0] StFtch = 4'd2;
  localparam logic [3:0] StAx0  = 4'd3;
  localparam logic [3:0] StAx1  = 4'd4;
  localparam logic [3:0] StAx2  = 4'd5;
  localparam logic [3:0] StAcc1 = 4'd6;
  localparam logic [3:0] StAcc2 = 4'd7;
  localparam logic [3:0] StEval = 4'd8;
  localparam logic [3:0] StDone = 4'd9;

  logic [3:0]        state_d, state_q;
  logic [CW-1:0]     j_d, j_q;
  logic [IdxW-1:0]   idx_d, idx_q;
  logic [CountW-1:0] count_d, count_q;
  logic              over_d, over_q;
  logic [SlotW-1:0]  img_d, img_q;
  logic              pend_vld_d, pend_vld_q;
  logic              out_vld_d, out_vld_q;
  logic [ACCW-1:0]   acc_d, acc_q;
  logic [ShiftW-1:0] sx_d, sx_q, sy_d, sy_q, sz_d, sz_q;
  logic [3*PW-1:0]   cen_d, cen_q;
  res_t              pend_d, pend_q, out_d, out_q, new_res;
  logic              last_d, last_q;

  logic [SlotW-1:0]     cnt_w, in_idx_w, idx_w, j_w;
  logic [CW-1:0]        cnt;
  logic [CountW-1:0]    lim;
  logic                 in_idx_ok, idx_ok, out_free, hit, shifted;
  logic [PW-1:0]        len_x, len_y, len_z, bx, by, bz;

  always_comb begin
    cnt_w = (SlotW'(cfg_i.atom_count) > MaxAtomsW) ? MaxAtomsW : SlotW'(cfg_i.atom_count);
    cnt   = cnt_w[CW-1:0];
    if (cfg_i.neigh_max == '0) begin
      lim = CountW'(1);
    end else if (cfg_i.neigh_max > NeighLimW) begin
      lim = NeighLimW;
    end else begin
      lim = cfg_i.neigh_max;
    end
    bx    = PW'(cfg_i.box_x);
    by    = PW'(cfg_i.box_y);
    bz    = PW'(cfg_i.box_z);
    len_x = (bx == '0) ? PW'(1) : bx;
    len_y = (by == '0) ? PW'(1) : by;
    len_z = (bz == '0) ? PW'(1) : bz;
  end

  assign in_idx_w  = SlotW'(in_index_i);
  assign idx_w     = SlotW'(idx_q);
  assign j_w       = SlotW'(j_q);
  assign in_idx_ok = in_idx_w < MaxAtomsW;
  assign idx_ok    = idx_w < MaxAtomsW;
  assign out_free  = !out_vld_q || out_ready_i;
  assign hit       = CMPW'(acc_q) < CMPW'(cfg_i.cutoff_sq);
  assign shifted   = (sx_q != ShiftNone) || (sy_q != ShiftNone) || (sz_q != ShiftNone);

  always_comb begin
    new_res                = '0;
    new_res.center_index   = idx_q;
    new_res.neighbor_index = j_w[IdxW-1:0];
    new_res.slot_index     = shifted ? img_q : j_w;
    new_res.shift_x        = sx_q;
    new_res.shift_y        = sy_q;
    new_res.shift_z        = sz_q;
    new_res.neighbor_valid = 1'b1;
    new_res.neighbor_count = count_q + 1'b1;
  end

  always_comb begin
    state_d    = state_q;
    j_d        = j_q;
    idx_d      = idx_q;
    count_d    = count_q;
    over_d     = over_q;
    img_d      = img_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    out_d      = out_q;
    last_d     = last_q;
    acc_d      = acc_q;
    sx_d       = sx_q;
    sy_d       = sy_q;
    sz_d       = sz_q;
    cen_d      = cen_q;
    ram_en_o   = 1'b0;
    ram_we_o   = 1'b0;
    ram_addr_o = j_q[AW-1:0];
    ram_wdata_o = {PW'(in_pos_z_i), PW'(in_pos_y_i), PW'(in_pos_x_i)};
    ax_a_o     = cen_q[PW-1:0];
    ax_b_o     = ram_rdata_i[PW-1:0];
    ax_len_o   = len_x;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (in_opcode_i == OpLoad) begin
            if (in_idx_ok) begin
              ram_en_o   = 1'b1;
              ram_we_o   = 1'b1;
              ram_addr_o = in_idx_w[AW-1:0];
              if (in_index_i == '0) begin
                img_d = cnt_w;
              end
            end
          end else begin
            idx_d      = in_index_i;
            count_d    = '0;
            over_d     = 1'b0;
            pend_vld_d = 1'b0;
            if (in_idx_ok) begin
              ram_en_o   = 1'b1;
              ram_addr_o = in_idx_w[AW-1:0];
              state_d    = StCen;
            end else begin
              state_d = StDone;
            end
          end
        end
      end
      StCen: begin
        cen_d   = ram_rdata_i;
        j_d     = '0;
        state_d = StFtch;
      end
      StFtch: begin
        if (j_q == cnt) begin
          state_d = StDone;
        end else if (j_w == idx_w) begin
          j_d = j_q + 1'b1;
        end else begin
          ram_en_o = 1'b1;
          state_d  = StAx0;
        end
      end
      StAx0: begin
        state_d = StAx1;
      end
      StAx1: begin
        ax_a_o   = cen_q[2*PW-1:PW];
        ax_b_o   = ram_rdata_i[2*PW-1:PW];
        ax_len_o = len_y;
        sx_d     = ax_shift_i;
        state_d  = StAx2;
      end
      StAx2: begin
        ax_a_o   = cen_q[3*PW-1:2*PW];
        ax_b_o   = ram_rdata_i[3*PW-1:2*PW];
        ax_len_o = len_z;
        sy_d     = ax_shift_i;
        acc_d    = ACCW'(ax_sq_i);
        state_d  = StAcc1;
      end
      StAcc1: begin
        sz_d    = ax_shift_i;
        acc_d   = acc_q + ACCW'(ax_sq_i);
        state_d = StAcc2;
      end
      StAcc2: begin
        acc_d   = acc_q + ACCW'(ax_sq_i);
        state_d = StEval;
      end
      StEval: begin
        priority if (!hit) begin
          j_d     = j_q + 1'b1;
          state_d = StFtch;
        end else if (count_q >= lim) begin
          over_d  = 1'b1;
          j_d     = j_q + 1'b1;
          state_d = StFtch;
        end else if (!pend_vld_q || out_free) begin
          if (pend_vld_q) begin
            out_vld_d = 1'b1;
            out_d     = pend_q;
            last_d    = 1'b0;
          end
          pend_d     = new_res;
          pend_vld_d = 1'b1;
          count_d    = count_q + 1'b1;
          if (shifted && (img_q != SlotMax)) begin
            img_d = img_q + 1'b1;
          end
          j_d     = j_q + 1'b1;
          state_d = StFtch;
        end else begin
          state_d = StEval;
        end
      end
      StDone: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          last_d    = 1'b1;
          if (pend_vld_q && idx_ok) begin
            out_d          = pend_q;
            out_d.overflow = over_q;
          end else begin
            out_d              = '0;
            out_d.center_index = idx_q;
          end
          pend_vld_d = 1'b0;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      img_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      j_q        <= '0;
      count_q    <= '0;
      over_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      img_q      <= img_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      j_q        <= j_d;
      count_q    <= count_d;
      over_q     <= over_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    acc_q  <= acc_d;
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    sz_q   <= sz_d;
    cen_q  <= cen_d;
    pend_q <= pend_d;
    out_q  <= out_d;
    last_q <= last_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;
  assign out_last_o  = last_q;

endmodule

/* hw/rtl/periodic_neighbor_list_core.sv */
// Periodic neighbor list core. A load word (tuser 0) writes one atom position into the
// position memory; loading atom 0 also restarts the image slot counter at atom_count
// (capped at MAX_ATOMS). A query word (tuser 1) scans every stored atom against the center
// atom with minimum-image shifts and streams one result word per neighbor inside the
// cutoff, up to the neighbor limit, the last one flagged by tlast; an empty list gives a
// single word with tuser low. A query holds s_axis_tready low while it fetches the center,
// then for each other atom does one memory read, x, y and z in turn through the single
// shared axis unit, two accumulate steps and one cutoff compare, and then closes the list;
// a stalled result output (m_axis_tready low) can hold it longer. Registers are written
// over the APB port at byte address 8 * index; the user must write them only while idle,
// and the block itself does not enforce it.
module periodic_neighbor_list_core #(
  parameter int unsigned MAX_ATOMS   = 1024,
  parameter int unsigned NEIGH_LIMIT = 64,
  parameter int unsigned POS_BITS    = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pnl_pkg::ApbAddrW-1:0]    paddr,
  input  logic [pnl_pkg::ApbDataW-1:0]    pwdata,
  output logic [pnl_pkg::ApbDataW-1:0]    prdata,
  output logic                            pready,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // atom_index, pos_x, pos_y, pos_z, zero pad
  input  logic [pnl_pkg::InTdataW-1:0]    s_axis_tdata,
  // opcode
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // center_index, neighbor_index, slot_index, shift_x, shift_y, shift_z,
  // neighbor_count, overflow, zero pad
  output logic [pnl_pkg::OutTdataW-1:0]   m_axis_tdata,
  // neighbor_valid
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast
);
  import pnl_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ATOMS);
  localparam int unsigned MW = 3 * POS_BITS;

  cfg_t                  cfg;
  res_t                  res;
  logic                  ram_en, ram_we;
  logic [AW-1:0]         ram_addr;
  logic [MW-1:0]         ram_wdata, ram_rdata;
  logic [POS_BITS-1:0]   ax_a, ax_b, ax_len;
  logic [1:0]            ax_shift;
  logic [2*POS_BITS-1:0] ax_sq;

  pnl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pnl_ram #(
    .Width (MW),
    .Depth (MAX_ATOMS)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  pnl_axis_unit #(
    .PosW (POS_BITS)
  ) u_axis (
    .clk_i   (clk_i),
    .a_i     (ax_a),
    .b_i     (ax_b),
    .len_i   (ax_len),
    .shift_o (ax_shift),
    .sq_o    (ax_sq)
  );

  pnl_seq #(
    .MAX_ATOMS   (MAX_ATOMS),
    .NEIGH_LIMIT (NEIGH_LIMIT),
    .POS_BITS    (POS_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_opcode_i (s_axis_tuser),
    .in_index_i  (s_axis_tdata[9:0]),
    .in_pos_x_i  (s_axis_tdata[33:10]),
    .in_pos_y_i  (s_axis_tdata[57:34]),
    .in_pos_z_i  (s_axis_tdata[81:58]),
    .ram_en_o    (ram_en),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata),
    .ax_a_o      (ax_a),
    .ax_b_o      (ax_b),
    .ax_len_o    (ax_len),
    .ax_shift_i  (ax_shift),
    .ax_sq_i     (ax_sq),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, res.overflow, res.neighbor_count, res.shift_z, res.shift_y,
                         res.shift_x, res.slot_index, res.neighbor_index, res.center_index};
  assign m_axis_tuser = res.neighbor_valid;

endmodule
